// ===== rtl/core/tcpc_pkg.sv =====
package tcpc_pkg;

    // Default number of symbols in a PIN
    localparam int PIN_LENGTH_DEF = 6;

    // Configuration port shape
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DOT_LIMIT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_CODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VERIFY_OPCODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SET_OPCODE    = 3'd4;

    // Register reset values
    localparam logic [15:0] DOT_LIMIT_RST     = 16'd500;
    localparam logic [15:0] TIMEOUT_RST       = 16'd5000;
    localparam logic [7:0]  CLASS_CODE_RST    = 8'd0;
    localparam logic [7:0]  VERIFY_OPCODE_RST = 8'd1;
    localparam logic [7:0]  SET_OPCODE_RST    = 8'd2;

    // Symbol codes
    localparam logic [1:0] SYM_NONE = 2'd0;
    localparam logic [1:0] SYM_DOT  = 2'd1;
    localparam logic [1:0] SYM_DASH = 2'd2;

    // Status codes
    localparam logic [2:0] ST_SET_OK        = 3'd0;
    localparam logic [2:0] ST_CONFIRMED     = 3'd1;
    localparam logic [2:0] ST_VERIFY_FAILED = 3'd2;
    localparam logic [2:0] ST_TIMEOUT       = 3'd3;
    localparam logic [2:0] ST_NO_PIN        = 3'd4;
    localparam logic [2:0] ST_BAD_OPCODE    = 3'd5;
    localparam logic [2:0] ST_BAD_CLASS     = 3'd6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  request_class;
        logic [7:0]  request_opcode;
        logic        pressed;
        logic [31:0] time_ms;
    } tcpc_in_t;

    typedef struct packed {
        logic       status_valid;
        logic [2:0] status_code;
        logic       led_on;
        logic       busy_res;
        logic       confirmed;
    } tcpc_out_t;

    typedef struct packed {
        logic [15:0] dot_limit_ms;
        logic [15:0] timeout_ms;
        logic [7:0]  class_code;
        logic [7:0]  verify_opcode;
        logic [7:0]  set_opcode;
    } tcpc_cfg_t;

endpackage

// ===== rtl/core/tcpc_core.sv =====
module tcpc_core #(
    parameter int PIN_LENGTH = tcpc_pkg::PIN_LENGTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  tcpc_pkg::tcpc_in_t  item,
    input  tcpc_pkg::tcpc_cfg_t cfg,
    output tcpc_pkg::tcpc_out_t res
);
    import tcpc_pkg::*;

    localparam int CW = $clog2(PIN_LENGTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_VERIFY = 2'd1,
        MODE_SET    = 2'd2
    } mode_t;

    mode_t                       mode_reg, mode_next;
    logic [PIN_LENGTH-1:0][1:0]  stored_pin_reg, stored_pin_next;
    logic [PIN_LENGTH-1:0][1:0]  entered_reg, entered_next;
    logic [PIN_LENGTH-1:0][1:0]  entered_add;
    logic [CW-1:0]               count_reg, count_next;
    logic                        last_level_reg, last_level_next;
    logic [31:0]                 mark_time_reg, mark_time_next;
    logic                        confirmed_reg, confirmed_next;
    logic                        indicator_reg, indicator_next;

    logic [31:0] gap;
    logic [1:0]  new_sym;
    logic        count_full;

    // Press length and the symbol it makes
    assign gap        = item.time_ms - mark_time_reg;
    assign new_sym    = (gap < {16'd0, cfg.dot_limit_ms}) ? SYM_DOT : SYM_DASH;
    assign count_full = (count_reg + CW'(1)) >= CW'(PIN_LENGTH);

    // Place the new symbol at the current count
    always_comb
    begin
        entered_add = entered_reg;
        for (int i = 0; i < PIN_LENGTH; i++)
        begin
            if (CW'(i) == count_reg)
            begin
                entered_add[i] = new_sym;
            end
        end
    end

    // Step the session for one item
    always_comb
    begin
        mode_next       = mode_reg;
        stored_pin_next = stored_pin_reg;
        entered_next    = entered_reg;
        count_next      = count_reg;
        last_level_next = last_level_reg;
        mark_time_next  = mark_time_reg;
        confirmed_next  = confirmed_reg;
        indicator_next  = indicator_reg;
        res             = '0;

        if (!item.kind)
        begin
            // Request: drop any open session, then judge it
            mode_next       = MODE_IDLE;
            entered_next    = '0;
            count_next      = '0;
            last_level_next = 1'b0;
            mark_time_next  = '0;
            indicator_next  = 1'b0;
            if (item.request_class != cfg.class_code)
            begin
                res.status_valid = 1'b1;
                res.status_code  = ST_BAD_CLASS;
            end
            else if (item.request_opcode == cfg.verify_opcode)
            begin
                if (stored_pin_reg[0] != SYM_NONE)
                begin
                    mode_next      = MODE_VERIFY;
                    mark_time_next = item.time_ms;
                end
                else
                begin
                    res.status_valid = 1'b1;
                    res.status_code  = ST_NO_PIN;
                end
            end
            else if (item.request_opcode == cfg.set_opcode)
            begin
                if (stored_pin_reg[0] == SYM_NONE || confirmed_reg)
                begin
                    mode_next      = MODE_SET;
                    mark_time_next = item.time_ms;
                end
                else
                begin
                    res.status_valid = 1'b1;
                    res.status_code  = ST_VERIFY_FAILED;
                end
            end
            else
            begin
                res.status_valid = 1'b1;
                res.status_code  = ST_BAD_OPCODE;
            end
        end
        else if (mode_reg != MODE_IDLE && item.pressed != last_level_reg)
        begin
            last_level_next = item.pressed;
            if (gap > {16'd0, cfg.timeout_ms})
            begin
                // Too long since the last press or the request: end the session
                res.status_valid = 1'b1;
                res.status_code  = ST_TIMEOUT;
                mode_next        = MODE_IDLE;
                entered_next     = '0;
                count_next       = '0;
                last_level_next  = 1'b0;
                mark_time_next   = '0;
                indicator_next   = 1'b0;
            end
            else if (item.pressed)
            begin
                mark_time_next = item.time_ms;
                indicator_next = 1'b1;
            end
            else
            begin
                indicator_next = 1'b0;
                entered_next   = entered_add;
                count_next     = count_reg + CW'(1);
                if (count_full)
                begin
                    // Last symbol in: check or store, then close the session
                    res.status_valid = 1'b1;
                    if (mode_reg == MODE_VERIFY)
                    begin
                        if (entered_add == stored_pin_reg)
                        begin
                            confirmed_next  = 1'b1;
                            res.status_code = ST_CONFIRMED;
                        end
                        else
                        begin
                            confirmed_next  = 1'b0;
                            res.status_code = ST_VERIFY_FAILED;
                        end
                    end
                    else
                    begin
                        stored_pin_next = entered_add;
                        res.status_code = ST_SET_OK;
                    end
                    mode_next       = MODE_IDLE;
                    entered_next    = '0;
                    count_next      = '0;
                    last_level_next = 1'b0;
                    mark_time_next  = '0;
                end
            end
        end

        res.led_on    = indicator_next;
        res.busy_res  = (mode_next != MODE_IDLE);
        res.confirmed = confirmed_next;
    end

    // Hold session state; advance on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            for (int i = 0; i < PIN_LENGTH; i++)
            begin
                stored_pin_reg[i] <= (i < PIN_LENGTH / 2) ? SYM_DOT : SYM_DASH;
            end
            entered_reg    <= '0;
            count_reg      <= '0;
            last_level_reg <= 1'b0;
            mark_time_reg  <= '0;
            confirmed_reg  <= 1'b0;
            indicator_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            stored_pin_reg <= stored_pin_next;
            entered_reg    <= entered_next;
            count_reg      <= count_next;
            last_level_reg <= last_level_next;
            mark_time_reg  <= mark_time_next;
            confirmed_reg  <= confirmed_next;
            indicator_reg  <= indicator_next;
        end
    end

`ifndef SYNTHESIS
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(PIN_LENGTH))
        else $error("symbol count reached PIN length inside a session");

    a_idle_no_symbols: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> count_reg == '0 && !indicator_reg)
        else $error("idle with leftover session state");

    a_idle_sample_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind && mode_reg == MODE_IDLE |-> !res.status_valid)
        else $error("status raised for a sample while idle");

    a_confirm_only_verify: assert property (@(posedge clk) disable iff (!rst_n)
        step && !confirmed_reg && confirmed_next |-> mode_reg == MODE_VERIFY)
        else $error("confirmed flag set outside a verify session");
`endif

endmodule

// ===== rtl/core/tap_code_pin_checker_top.sv =====
// Tap-code PIN lock. A request item (kind 0) opens a verify or set session;
// button level items (kind 1) carrying a millisecond timestamp are turned
// into dots and dashes, and after PIN_LENGTH symbols the entry is checked
// against, or stored as, the PIN. Every input item gives exactly one result
// item, held in the input register and then offered from the result register;
// one item is taken per clock as long as results are drained, with the input
// register and the result register decoupling the two channels. The whole
// session step is one pass of combinational logic between those registers,
// the longest path being the 32-bit timestamp subtract and compare.
// Configuration registers are written at any clock with cfg_we high and take
// effect on the next item.
module tap_code_pin_checker_top #(
    parameter int PIN_LENGTH = tcpc_pkg::PIN_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tcpc_pkg::tcpc_in_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tcpc_pkg::tcpc_out_t                  out_item,
    input  logic                                 cfg_we,
    input  logic [tcpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tcpc_pkg::*;

    tcpc_cfg_t cfg_reg;
    logic      in_valid_reg;
    tcpc_in_t  in_item_reg;
    logic      out_valid_reg;
    tcpc_out_t out_item_reg;
    tcpc_out_t res;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_limit_ms  <= DOT_LIMIT_RST;
            cfg_reg.timeout_ms    <= TIMEOUT_RST;
            cfg_reg.class_code    <= CLASS_CODE_RST;
            cfg_reg.verify_opcode <= VERIFY_OPCODE_RST;
            cfg_reg.set_opcode    <= SET_OPCODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DOT_LIMIT:     cfg_reg.dot_limit_ms  <= cfg_data;
                REG_TIMEOUT:       cfg_reg.timeout_ms    <= cfg_data;
                REG_CLASS_CODE:    cfg_reg.class_code    <= cfg_data[7:0];
                REG_VERIFY_OPCODE: cfg_reg.verify_opcode <= cfg_data[7:0];
                REG_SET_OPCODE:    cfg_reg.set_opcode    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    tcpc_core #(
        .PIN_LENGTH (PIN_LENGTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

endmodule

// ===== bench/tcpc_lock_checker.sv =====
`timescale 1ns / 100ps

// Watches the item channels and the register port of the tap-code PIN lock,
// predicts one status item per accepted input item and compares it with what
// the block returns.
module tcpc_lock_checker #(
    parameter int PIN_LENGTH = tcpc_pkg::PIN_LENGTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  tcpc_pkg::tcpc_in_t                  in_item,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  tcpc_pkg::tcpc_out_t                 out_item,
    input  logic                                cfg_we,
    input  logic [tcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  pending_count,
    output logic [PIN_LENGTH-1:0][1:0]          pin_now,
    output logic                                pin_ok_now
);
    import tcpc_pkg::*;

    typedef enum logic [1:0] {
        LOCK_IDLE   = 2'd0,
        LOCK_VERIFY = 2'd1,
        LOCK_SET    = 2'd2
    } lock_mode_t;

    // Register copies
    logic [15:0] dot_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  class_reg;
    logic [7:0]  verify_reg;
    logic [7:0]  set_reg;

    // Lock state
    lock_mode_t                   mode;
    logic [PIN_LENGTH-1:0][1:0]   pin_store;
    logic [PIN_LENGTH-1:0][1:0]   pin_entry;
    int                           sym_count;
    logic                         level_now;
    logic [31:0]                  mark_ms;
    logic                         pin_ok;
    logic                         led;

    // Status items still owed by the block, oldest first
    tcpc_out_t expected_status_q[$];

    assign pin_now    = pin_store;
    assign pin_ok_now = pin_ok;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic void end_session();
        mode      = LOCK_IDLE;
        pin_entry = '0;
        sym_count = 0;
        level_now = 1'b0;
        mark_ms   = '0;
        led       = 1'b0;
    endfunction

    function automatic void restore_reset_state();
        dot_reg     = DOT_LIMIT_RST;
        timeout_reg = TIMEOUT_RST;
        class_reg   = CLASS_CODE_RST;
        verify_reg  = VERIFY_OPCODE_RST;
        set_reg     = SET_OPCODE_RST;
        // first half dots, rest dashes
        for (int i = 0; i < PIN_LENGTH; i++)
            pin_store[i] = (i < PIN_LENGTH / 2) ? SYM_DOT : SYM_DASH;
        pin_ok = 1'b0;
        end_session();
        expected_status_q.delete();
        fail_count    = 0;
        pending_count = 0;
    endfunction

    // Advance the lock by one input item and return the status it causes
    function automatic tcpc_out_t predict_status(input tcpc_in_t it);
        tcpc_out_t   res;
        logic [31:0] gap;
        res = '0;
        if (it.kind == 1'b0) begin
            end_session();
            if (it.request_class != class_reg) begin
                res.status_valid = 1'b1;
                res.status_code  = ST_BAD_CLASS;
            end else if (it.request_opcode == verify_reg) begin
                if (pin_store[0] != SYM_NONE) begin
                    mode    = LOCK_VERIFY;
                    mark_ms = it.time_ms;
                end else begin
                    res.status_valid = 1'b1;
                    res.status_code  = ST_NO_PIN;
                end
            end else if (it.request_opcode == set_reg) begin
                if (pin_store[0] == SYM_NONE || pin_ok) begin
                    mode    = LOCK_SET;
                    mark_ms = it.time_ms;
                end else begin
                    res.status_valid = 1'b1;
                    res.status_code  = ST_VERIFY_FAILED;
                end
            end else begin
                res.status_valid = 1'b1;
                res.status_code  = ST_BAD_OPCODE;
            end
        end else if (mode != LOCK_IDLE && it.pressed != level_now) begin
            gap       = it.time_ms - mark_ms;
            level_now = it.pressed;
            if (gap > {16'd0, timeout_reg}) begin
                res.status_valid = 1'b1;
                res.status_code  = ST_TIMEOUT;
                end_session();
            end else if (it.pressed) begin
                mark_ms = it.time_ms;
                led     = 1'b1;
            end else begin
                led = 1'b0;
                if (sym_count < PIN_LENGTH) begin
                    pin_entry[sym_count] = (gap < {16'd0, dot_reg}) ? SYM_DOT : SYM_DASH;
                    sym_count++;
                end
                // full entry: judge or store it
                if (sym_count >= PIN_LENGTH) begin
                    res.status_valid = 1'b1;
                    if (mode == LOCK_VERIFY) begin
                        pin_ok          = (pin_entry == pin_store);
                        res.status_code = pin_ok ? ST_CONFIRMED : ST_VERIFY_FAILED;
                    end else begin
                        pin_store       = pin_entry;
                        res.status_code = ST_SET_OK;
                    end
                    end_session();
                end
            end
        end
        res.led_on    = led;
        res.busy_res  = (mode != LOCK_IDLE);
        res.confirmed = pin_ok;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch_channels
        tcpc_out_t want;
        if (!rst_n) begin
            restore_reset_state();
        end else begin
            // mirror register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_DOT_LIMIT:     dot_reg     = cfg_data[15:0];
                    REG_TIMEOUT:       timeout_reg = cfg_data[15:0];
                    REG_CLASS_CODE:    class_reg   = cfg_data[7:0];
                    REG_VERIFY_OPCODE: verify_reg  = cfg_data[7:0];
                    REG_SET_OPCODE:    set_reg     = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                expected_status_q.push_back(predict_status(in_item));

            // compare returned item with the oldest prediction
            if (out_valid && out_ready) begin
                if (expected_status_q.size() == 0) begin
                    note_mismatch("unrequested status item", 32'(out_item), '0);
                end else begin
                    want = expected_status_q.pop_front();
                    if (out_item.status_valid !== want.status_valid)
                        note_mismatch("status_valid", 32'(out_item.status_valid),
                                      32'(want.status_valid));
                    if (out_item.status_code !== want.status_code)
                        note_mismatch("status_code", 32'(out_item.status_code),
                                      32'(want.status_code));
                    if (out_item.led_on !== want.led_on)
                        note_mismatch("led_on", 32'(out_item.led_on), 32'(want.led_on));
                    if (out_item.busy_res !== want.busy_res)
                        note_mismatch("busy_res", 32'(out_item.busy_res),
                                      32'(want.busy_res));
                    if (out_item.confirmed !== want.confirmed)
                        note_mismatch("confirmed", 32'(out_item.confirmed),
                                      32'(want.confirmed));
                end
            end
            pending_count = expected_status_q.size();
        end
    end

endmodule

// ===== bench/tb_tap_code_pin_checker_top.sv =====
`timescale 1ns / 100ps

module tb_tap_code_pin_checker_top;

    import tcpc_pkg::*;

    localparam int PIN_LEN         = PIN_LENGTH_DEF;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_ITEMS     = 320;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef logic [PIN_LEN-1:0][1:0] pin_t;

    typedef enum {
        FAULT_NONE,
        FAULT_TIMEOUT,
        FAULT_ABORT
    } fault_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    tcpc_in_t               in_item;
    logic                   out_valid;
    logic                   out_ready;
    tcpc_out_t              out_item;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   fail_count;
    int   pending_count;
    pin_t pin_now;
    logic pin_ok_now;

    // Stimulus knobs and register shadows
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_req_cnt;
    logic [31:0] t_now;
    logic [15:0] cur_dot;
    logic [15:0] cur_tmo;
    logic [7:0]  cur_class;
    logic [7:0]  cur_vop;
    logic [7:0]  cur_sop;
    int          items_done;
    int unsigned cycles;

    tap_code_pin_checker_top #(
        .PIN_LENGTH (PIN_LEN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcpc_lock_checker #(
        .PIN_LENGTH (PIN_LEN)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .pin_now       (pin_now),
        .pin_ok_now    (pin_ok_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request
    initial
    begin
        int holds_done;
        holds_done = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req_cnt != holds_done)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
                out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // Offer one item, with optional idle cycles first, and hold it until taken
    task automatic drive_item(input logic kind, input logic [7:0] cls,
                              input logic [7:0] op, input logic pressed,
                              input logic [31:0] tm);
        tcpc_in_t it;
        it.kind           = kind;
        it.request_class  = cls;
        it.request_opcode = op;
        it.pressed        = pressed;
        it.time_ms        = tm;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_done++;
    endtask

    // Stop offering until every owed status item is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] dot, input logic [15:0] tmo,
                             input logic [7:0] cls, input logic [7:0] vop,
                             input logic [7:0] sop);
        wait_drained();
        repeat (3) @(negedge clk);
        write_reg(REG_DOT_LIMIT, dot);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_CLASS_CODE, {8'd0, cls});
        write_reg(REG_VERIFY_OPCODE, {8'd0, vop});
        write_reg(REG_SET_OPCODE, {8'd0, sop});
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_dot   = dot;
        cur_tmo   = tmo;
        cur_class = cls;
        cur_vop   = vop;
        cur_sop   = sop;
    endtask

    // Press length that yields the wanted symbol without running into the timeout
    function automatic logic [31:0] pick_hold(input logic [1:0] sym);
        logic [31:0] dl;
        logic [31:0] tl;
        logic [31:0] hi;
        dl = cur_dot;
        tl = cur_tmo;
        if (sym == SYM_DOT)
        begin
            if (dl == 0)
                return 0;
            hi = (dl - 1 < tl) ? dl - 1 : tl;
            if ($urandom_range(9) == 0)
                return hi;
            return $urandom_range(hi);
        end
        hi = (tl >= dl) ? tl - dl : 0;
        if (hi > 2000)
            hi = 2000;
        if ($urandom_range(9) == 0)
            return dl;
        return dl + $urandom_range(hi);
    endfunction

    // Pause before a press, keeping the gap since the last press within the timeout
    function automatic logic [31:0] pick_idle(input logic [31:0] prev_hold);
        logic [31:0] room;
        room = ({16'd0, cur_tmo} >= prev_hold) ? cur_tmo - prev_hold : 0;
        if ($urandom_range(9) == 0)
            return room;
        return $urandom_range((room > 3000) ? 3000 : room);
    endfunction

    function automatic pin_t random_pin();
        pin_t p;
        for (int i = 0; i < PIN_LEN; i++)
            p[i] = $urandom_range(1) ? SYM_DASH : SYM_DOT;
        return p;
    endfunction

    // One request followed by a tapped entry, optionally broken at one symbol
    task automatic play_session(input logic [7:0] op, input pin_t syms,
                                input fault_t fault, input int fault_pos);
        logic [31:0] hold;
        logic [31:0] prev_hold;
        // move the clock base now and then, across the wrap too
        if ($urandom_range(3) == 0)
            t_now = $urandom;
        if ($urandom_range(15) == 0)
            t_now = 32'hFFFF_FFFF - $urandom_range(20000);
        drive_item(1'b0, cur_class, op, rand_bit(), t_now);
        prev_hold = 0;
        for (int i = 0; i < PIN_LEN; i++)
        begin
            if (fault == FAULT_TIMEOUT && i == fault_pos)
            begin
                if ($urandom_range(1))
                begin
                    t_now += cur_tmo + 1 + $urandom_range(3000);
                    drive_item(1'b1, rand_byte(), rand_byte(), 1'b1, t_now);
                end
                else
                begin
                    t_now += pick_idle(prev_hold);
                    drive_item(1'b1, rand_byte(), rand_byte(), 1'b1, t_now);
                    t_now += cur_tmo + 1 + $urandom_range(3000);
                    drive_item(1'b1, rand_byte(), rand_byte(), 1'b0, t_now);
                end
                return;
            end
            if (fault == FAULT_ABORT && i == fault_pos)
            begin
                drive_item(1'b0, $urandom_range(1) ? cur_class : rand_byte(), rand_byte(),
                           rand_bit(), t_now);
                return;
            end
            t_now += pick_idle(prev_hold);
            drive_item(1'b1, rand_byte(), rand_byte(), 1'b1, t_now);
            // repeated level, dropped by the lock
            if ($urandom_range(99) < 8)
                drive_item(1'b1, rand_byte(), rand_byte(), 1'b1,
                           t_now + $urandom_range(50));
            hold = pick_hold(syms[i]);
            t_now += hold;
            drive_item(1'b1, rand_byte(), rand_byte(), 1'b0, t_now);
            prev_hold = hold;
        end
    endtask

    task automatic run_random_session();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            play_session(cur_vop, pin_now, FAULT_NONE, 0);
        else if (r < 55)
            play_session(cur_vop, random_pin(), FAULT_NONE, 0);
        else if (r < 75)
        begin
            // unlock first so the set is allowed
            if (!pin_ok_now)
                play_session(cur_vop, pin_now, FAULT_NONE, 0);
            play_session(cur_sop, random_pin(), FAULT_NONE, 0);
        end
        else if (r < 85)
            play_session($urandom_range(1) ? cur_sop : cur_vop, random_pin(),
                         FAULT_TIMEOUT, $urandom_range(PIN_LEN - 1));
        else if (r < 92)
            play_session($urandom_range(1) ? cur_sop : cur_vop, random_pin(),
                         FAULT_ABORT, $urandom_range(PIN_LEN - 1));
        else if (r < 96)
            drive_item(1'b0, $urandom_range(1) ? cur_class : rand_byte(), rand_byte(),
                       rand_bit(), t_now);
        else
            repeat ($urandom_range(4, 1))
                drive_item(rand_bit(), rand_byte(), rand_byte(), rand_bit(), $urandom);
    endtask

    task automatic run_phase(input int target);
        int base;
        base = items_done;
        while (items_done - base < target)
            run_random_session();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_item         = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_req_cnt = 0;
        items_done      = 0;
        cur_dot         = DOT_LIMIT_RST;
        cur_tmo         = TIMEOUT_RST;
        cur_class       = CLASS_CODE_RST;
        cur_vop         = VERIFY_OPCODE_RST;
        cur_sop         = SET_OPCODE_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part on reset register values
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd0);        // level while idle
        drive_item(1'b0, CLASS_CODE_RST ^ 8'h01, VERIFY_OPCODE_RST, 1'b0, 32'd10);
        drive_item(1'b0, CLASS_CODE_RST, 8'hFF, 1'b1, 32'd20);          // unknown opcode
        drive_item(1'b0, CLASS_CODE_RST, SET_OPCODE_RST, 1'b0, 32'd30); // set, locked
        // correct entry of the reset PIN, with gaps right at both limits
        drive_item(1'b0, CLASS_CODE_RST, VERIFY_OPCODE_RST, 1'b0, 32'd1000);
        drive_item(1'b1, 8'hFF, 8'hFF, 1'b1, 32'd1000);
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd1003);     // same level again
        drive_item(1'b1, 8'hFF, 8'h00, 1'b0, 32'd1499);     // dot, one under limit
        drive_item(1'b1, 8'h00, 8'hFF, 1'b1, 32'd2000);
        drive_item(1'b1, 8'h00, 8'h00, 1'b0, 32'd2000);     // dot, zero length
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd7000);     // gap equal to timeout
        drive_item(1'b1, 8'h00, 8'h00, 1'b0, 32'd7001);
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd7100);
        drive_item(1'b1, 8'h00, 8'h00, 1'b0, 32'd7600);     // dash, at limit
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd8000);
        drive_item(1'b1, 8'h00, 8'h00, 1'b0, 32'd13000);    // dash, held to timeout
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd13000);
        drive_item(1'b1, 8'h00, 8'h00, 1'b0, 32'd13500);
        // set allowed now, then let it time out
        drive_item(1'b0, CLASS_CODE_RST, SET_OPCODE_RST, 1'b1, 32'd20000);
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'd25001);
        // press across the clock wrap, then abort by a bad request
        drive_item(1'b0, CLASS_CODE_RST, VERIFY_OPCODE_RST, 1'b0, 32'hFFFF_FFF0);
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'hFFFF_FFFF);
        drive_item(1'b1, 8'h00, 8'h00, 1'b0, 32'h0000_0010);
        drive_item(1'b0, 8'hFF, 8'h00, 1'b1, 32'h0000_0020);
        drive_item(1'b1, 8'h00, 8'h00, 1'b1, 32'h0000_0030);

        t_now = 32'd100000;

        // Sender idles rarely, receiver often
        tx_idle_pct = 16;
        rx_idle_pct = 87;
        configure(16'd300, 16'd3000, 8'hA5, 8'h20, 8'hDA);
        run_phase(PHASE_ITEMS);
        begin
            logic [7:0] vop;
            vop = rand_byte();
            configure(16'($urandom_range(800, 100)), 16'($urandom_range(8000, 2000)),
                      rand_byte(), vop, vop ^ 8'h5A);
        end
        run_phase(PHASE_ITEMS);

        // Swap: sender idles often, receiver rarely; register extremes
        tx_idle_pct = 87;
        rx_idle_pct = 16;
        configure(16'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'h00);
        run_phase(PHASE_ITEMS);
        configure(16'hFFFF, 16'd0, 8'h00, 8'h00, 8'hFF);
        run_phase(PHASE_ITEMS);

        // No idling; equal opcodes first
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(16'd700, 16'd4000, 8'h3C, 8'h33, 8'h33);
        run_phase(PHASE_ITEMS);
        configure(DOT_LIMIT_RST, TIMEOUT_RST, 8'h81, 8'h7E, 8'h01);
        // long receiver hold-off while items keep coming, then a full drain
        rx_hold_req_cnt++;
        run_phase(60);
        wait_drained();
        run_phase(PHASE_ITEMS - 60);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
